FILE: design/ppfs_pkg.sv
// Shared constants and types for the packed pixel frame store.
// Used by the top level and by the port checker; no dependencies.
`default_nettype none

package ppfs_pkg;

  // Default sizing
  localparam int MEM_BYTES_DEF   = 4096;
  localparam int MAX_CH_BITS_DEF = 8;

  // Field widths
  localparam int POS_W   = 12;
  localparam int CH_W    = 8;
  localparam int WIDTH_W = 13;
  localparam int BITS_W  = 4;
  localparam int PB_W    = 6;   // pixel bits, up to four channels of eight
  localparam int BADDR_W = 32;  // bit address of a pixel
  localparam int WIN_W   = 40;  // five bytes cover any pixel at any bit offset
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 13;
  localparam int IN_DW   = 56;
  localparam int OUT_DW  = 32;

  // Commands carried on in_tuser
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RED_BITS     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GREEN_BITS   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BLUE_BITS    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ALPHA_BITS   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GRAY_MODE    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_ALPHA_ENABLE = 3'd6;

  // Register reset values
  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd64;
  localparam logic [BITS_W-1:0]  RST_RED_BITS    = 4'd5;
  localparam logic [BITS_W-1:0]  RST_GREEN_BITS  = 4'd6;
  localparam logic [BITS_W-1:0]  RST_BLUE_BITS   = 4'd5;
  localparam logic [BITS_W-1:0]  RST_ALPHA_BITS  = 4'd0;

  // Alpha reported when no alpha channel is stored
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef logic [CH_W-1:0] chan_t;

endpackage

`default_nettype wire

FILE: design/packed_pixel_frame_store.sv
// Packed pixel frame store: top level with sequencer, shared multiply-add unit
// and byte RAM. Depends on ppfs_pkg and ppfs_ram.
//
// Usage:
//   in_*  : one transaction per pixel access. in_tuser is the command
//           (0 read, 1 write); in_tdata carries position and channel values.
//   out_* : one result transaction per input: read fields on a read, zeros on
//           a write, and out_tuser flags an access past the end of memory.
//   cfg_* : register writes, taken at any edge with cfg_we high; write them
//           only while no pixel access is in flight.
// Timing: a single multiply-add unit forms y*width+x, then times pixel bits,
// to give the bit address (MUL1, MUL2). The pixel then spans n = 0..5 bytes,
// each read through the registered RAM port (RADDR, RDATA) and, for a write,
// written back one per cycle. One access is in flight at a time.
// Reset: after rst_n is released the block zeroes the RAM, one byte a cycle,
// with in_tready low until all are zeroed. Registers reload their defaults.
// Back-pressure: the result sits in an output register; a new access is taken
// while it waits, and the sequencer holds the following result until the
// register frees up.
`default_nettype none

module packed_pixel_frame_store #(
  parameter int MEM_BYTES        = ppfs_pkg::MEM_BYTES_DEF,
  parameter int MAX_CHANNEL_BITS = ppfs_pkg::MAX_CH_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pos_x[11:0], pos_y[23:12], in_red[31:24], in_green[39:32],
  // in_blue[47:40], in_alpha[55:48]
  input  wire logic [ppfs_pkg::IN_DW-1:0]  in_tdata,
  input  wire logic                        in_tuser,   // command
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic      [ppfs_pkg::OUT_DW-1:0] out_tdata,
  output logic                             out_tuser,  // out_of_range
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic                        cfg_we,
  input  wire logic [ppfs_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [ppfs_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int PBW = ppfs_pkg::PB_W;
  localparam int WW  = ppfs_pkg::WIN_W;
  localparam int BW  = ppfs_pkg::BADDR_W;
  localparam logic [BW:0] MEM_BITS = (BW+1)'(MEM_BYTES) << 3;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MUL1   = 4'd2;
  localparam logic [3:0] ST_MUL2   = 4'd3;
  localparam logic [3:0] ST_ADDR   = 4'd4;
  localparam logic [3:0] ST_RADDR  = 4'd5;
  localparam logic [3:0] ST_RDATA  = 4'd6;
  localparam logic [3:0] ST_MERGE  = 4'd7;
  localparam logic [3:0] ST_WRITE  = 4'd8;
  localparam logic [3:0] ST_RESULT = 4'd9;

  function automatic logic [31:0] mask32(input logic [PBW-1:0] n);
    logic [32:0] t;
    t = (33'd1 << n) - 33'd1;
    return t[31:0];
  endfunction

  function automatic logic [3:0] clamp_bits(input logic [3:0] n);
    return (n > 4'(MAX_CHANNEL_BITS)) ? 4'(MAX_CHANNEL_BITS) : n;
  endfunction

  // Configuration
  logic [ppfs_pkg::WIDTH_W-1:0] width_r;
  logic [ppfs_pkg::BITS_W-1:0]  red_bits_r, green_bits_r, blue_bits_r, alpha_bits_r;
  logic                         gray_r, alpha_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= ppfs_pkg::RST_IMAGE_WIDTH;
      red_bits_r   <= ppfs_pkg::RST_RED_BITS;
      green_bits_r <= ppfs_pkg::RST_GREEN_BITS;
      blue_bits_r  <= ppfs_pkg::RST_BLUE_BITS;
      alpha_bits_r <= ppfs_pkg::RST_ALPHA_BITS;
      gray_r       <= 1'b0;
      alpha_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ppfs_pkg::REG_IMAGE_WIDTH:  width_r      <= cfg_wdata;
        ppfs_pkg::REG_RED_BITS:     red_bits_r   <= cfg_wdata[3:0];
        ppfs_pkg::REG_GREEN_BITS:   green_bits_r <= cfg_wdata[3:0];
        ppfs_pkg::REG_BLUE_BITS:    blue_bits_r  <= cfg_wdata[3:0];
        ppfs_pkg::REG_ALPHA_BITS:   alpha_bits_r <= cfg_wdata[3:0];
        ppfs_pkg::REG_GRAY_MODE:    gray_r       <= cfg_wdata[0];
        ppfs_pkg::REG_ALPHA_ENABLE: alpha_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective channel widths
  logic [3:0]     rb, gb, bb, ab;
  logic [PBW-1:0] pb;

  always_comb begin
    rb = clamp_bits(red_bits_r);
    gb = gray_r ? 4'd0 : clamp_bits(green_bits_r);
    bb = gray_r ? 4'd0 : clamp_bits(blue_bits_r);
    ab = alpha_en_r ? clamp_bits(alpha_bits_r) : 4'd0;
    pb = PBW'(rb) + PBW'(gb) + PBW'(bb) + PBW'(ab);
  end

  // Sequencer and datapath registers
  logic [3:0]                  state_r, state_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic                        cmd_r, cmd_nxt;
  logic [ppfs_pkg::POS_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  ppfs_pkg::chan_t             red_r, red_nxt, green_r, green_nxt;
  ppfs_pkg::chan_t             blue_r, blue_nxt, alpha_r, alpha_nxt;
  ppfs_pkg::chan_t             lum_r, lum_nxt;
  logic [BW-1:0]               prod_r, prod_nxt;
  logic                        oor_r, oor_nxt;
  logic [2:0]                  off_r, off_nxt;
  logic [AW-1:0]               base_r, base_nxt;
  logic [2:0]                  nbytes_r, nbytes_nxt;
  logic [2:0]                  k_r, k_nxt;
  logic [WW-1:0]               win_r, win_nxt;
  logic [ppfs_pkg::OUT_DW-1:0] odata_r, odata_nxt;
  logic                        oor_out_r, oor_out_nxt;
  logic                        ovalid_r, ovalid_nxt;

  // Shared multiply-add unit
  logic [25:0] mac_a, mac_c;
  logic [12:0] mac_b;
  logic [38:0] mac_full;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Combinational helpers
  logic [BW:0]    end_bits;
  logic [PBW:0]   nb_sum;
  logic [PBW-1:0] win_sh;
  logic [9:0]     rgb_sum;
  logic [19:0]    lum_prod;
  logic [31:0]    pm, v_rd, v_wr, c1;
  logic [WW-1:0]  wmask, win_merged, win_shifted;
  ppfs_pkg::chan_t f_red, f_green, f_blue, f_alpha;
  logic           in_acc;

  ppfs_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    // Multiply-add operand select
    if (state_r == ST_MUL1) begin
      mac_a = 26'(y_r);
      mac_b = width_r;
      mac_c = 26'(x_r);
    end else begin
      mac_a = prod_r[25:0];
      mac_b = 13'(pb);
      mac_c = 26'd0;
    end
    mac_full = mac_a * mac_b + 39'(mac_c);

    // Range and byte span of the pixel
    end_bits = {1'b0, prod_r} + (BW+1)'(pb);
    nb_sum   = (PBW+1)'(prod_r[2:0]) + (PBW+1)'(pb) + (PBW+1)'(7);

    // Luminance: floor(sum/3) via multiply by 683 and shift by 11
    rgb_sum  = 10'(red_r) + 10'(green_r) + 10'(blue_r);
    lum_prod = 20'(rgb_sum) * 20'd683;

    // Pixel position inside the five-byte window
    win_sh = PBW'(WW) - PBW'(off_r) - pb;
    pm     = mask32(pb);
    v_rd   = 32'(win_r >> win_sh) & pm;

    // Pack a pixel for writing; in gray mode green and blue widths are zero
    c1   = 32'(gray_r ? lum_r : red_r) & mask32(PBW'(rb));
    v_wr = (c1 << (PBW'(gb) + PBW'(bb) + PBW'(ab)))
         | ((32'(green_r) & mask32(PBW'(gb))) << (PBW'(bb) + PBW'(ab)))
         | ((32'(blue_r) & mask32(PBW'(bb))) << PBW'(ab))
         | (32'(alpha_r) & mask32(PBW'(ab)));
    wmask      = WW'(pm) << win_sh;
    win_merged = (win_r & ~wmask) | ((WW'(v_wr) << win_sh) & wmask);
    win_shifted = win_r << {k_r, 3'b000};

    // Unpack a read pixel
    f_alpha = 8'(v_rd & mask32(PBW'(ab)));
    f_blue  = 8'((v_rd >> ab) & mask32(PBW'(bb)));
    f_green = 8'((v_rd >> (PBW'(ab) + PBW'(bb))) & mask32(PBW'(gb)));
    f_red   = 8'((v_rd >> (PBW'(ab) + PBW'(bb) + PBW'(gb))) & mask32(PBW'(rb)));
    if (gray_r) begin
      f_red   = 8'((v_rd >> ab) & mask32(PBW'(rb)));
      f_green = f_red;
      f_blue  = f_red;
    end
    if (oor_r) begin
      f_red   = '0;
      f_green = '0;
      f_blue  = '0;
      f_alpha = '0;
    end
    if (!alpha_en_r) begin
      f_alpha = ppfs_pkg::ALPHA_OPAQUE;
    end
    if (cmd_r == ppfs_pkg::CMD_WRITE) begin
      f_red   = '0;
      f_green = '0;
      f_blue  = '0;
      f_alpha = '0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cmd_nxt     = cmd_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    blue_nxt    = blue_r;
    alpha_nxt   = alpha_r;
    lum_nxt     = lum_r;
    prod_nxt    = prod_r;
    oor_nxt     = oor_r;
    off_nxt     = off_r;
    base_nxt    = base_r;
    nbytes_nxt  = nbytes_r;
    k_nxt       = k_r;
    win_nxt     = win_r;
    odata_nxt   = odata_r;
    oor_out_nxt = oor_out_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ram_we      = 1'b0;
    ram_waddr   = base_r + AW'(k_r);
    ram_wdata   = win_shifted[WW-1 -: 8];
    ram_raddr   = base_r + AW'(k_r);

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 8'd0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MEM_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_tuser;
          x_nxt     = in_tdata[11:0];
          y_nxt     = in_tdata[23:12];
          red_nxt   = in_tdata[31:24];
          green_nxt = in_tdata[39:32];
          blue_nxt  = in_tdata[47:40];
          alpha_nxt = in_tdata[55:48];
          win_nxt   = '0;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_nxt  = mac_full[BW-1:0];
        lum_nxt   = lum_prod[18:11];
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = mac_full[BW-1:0];
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        oor_nxt    = end_bits > MEM_BITS;
        off_nxt    = prod_r[2:0];
        base_nxt   = prod_r[AW+2:3];
        nbytes_nxt = nb_sum[5:3];
        k_nxt      = 3'd0;
        // Skip memory for an empty pixel or an access past the end
        if ((end_bits > MEM_BITS) || (nb_sum[5:3] == 3'd0)) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_RADDR;
        end
      end
      ST_RADDR: begin
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        for (int i = 0; i < 5; i++) begin
          if (k_r == 3'(i)) begin
            win_nxt[WW-1-8*i -: 8] = ram_rdata;
          end
        end
        k_nxt = k_r + 3'd1;
        if (k_r + 3'd1 == nbytes_r) begin
          state_nxt = (cmd_r == ppfs_pkg::CMD_WRITE) ? ST_MERGE : ST_RESULT;
        end else begin
          state_nxt = ST_RADDR;
        end
      end
      ST_MERGE: begin
        win_nxt   = win_merged;
        k_nxt     = 3'd0;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        k_nxt  = k_r + 3'd1;
        if (k_r + 3'd1 == nbytes_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // Hold until the output register is free
        if (!ovalid_r || out_tready) begin
          odata_nxt   = {f_alpha, f_blue, f_green, f_red};
          oor_out_nxt = oor_r;
          ovalid_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      k_r      <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    red_r     <= red_nxt;
    green_r   <= green_nxt;
    blue_r    <= blue_nxt;
    alpha_r   <= alpha_nxt;
    lum_r     <= lum_nxt;
    prod_r    <= prod_nxt;
    oor_r     <= oor_nxt;
    off_r     <= off_nxt;
    base_r    <= base_nxt;
    nbytes_r  <= nbytes_nxt;
    win_r     <= win_nxt;
    odata_r   <= odata_nxt;
    oor_out_r <= oor_out_nxt;
  end

  assign out_tdata  = odata_r;
  assign out_tuser  = oor_out_r;
  assign out_tvalid = ovalid_r;

endmodule

`default_nettype wire

FILE: design/ppfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/ppfs_checker.sv
// Port-level checker for the packed pixel frame store, bound to the top level.
// Depends on ppfs_pkg.
`default_nettype none

module ppfs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [ppfs_pkg::OUT_DW-1:0] out_tdata,
  input wire logic                        out_tuser
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // The memory clearing pass keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  // One access at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second transaction taken while one is in flight");

  // No result without a matching input transaction
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result transaction without an accepted input");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more than two transactions outstanding");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind packed_pixel_frame_store ppfs_checker u_ppfs_checker (.*);

`default_nettype wire
